// ----- hw/rtl/tfr_pkg.sv -----
// shared types, character codes and limits of the text frame receiver
package tfr_pkg;

  // protocol characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // largest number of text bytes in one text frame
  localparam int unsigned TEXT_LIMIT = 128;

  // digit limits of the decimal fields
  localparam logic [2:0] ID_DIGITS  = 3'd3;
  localparam logic [2:0] NUM_DIGITS = 3'd5;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEXT_START  = 2'd0,
    CFG_ACK_START   = 2'd1,
    CFG_BIN_START   = 2'd2,
    CFG_MAX_PAYLOAD = 2'd3
  } cfg_reg_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // frame types
  typedef enum logic [1:0] {
    FRAME_TEXT = 2'd0,
    FRAME_ACK  = 2'd1,
    FRAME_BIN  = 2'd2
  } frame_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NUMBER   = 3'd1,
    ERR_SEP      = 3'd2,
    ERR_TOO_BIG  = 3'd3,
    ERR_CHECKSUM = 3'd4,
    ERR_ABORT    = 3'd5,
    ERR_OVERFLOW = 3'd6
  } err_e;

  // start characters as programmed
  typedef struct packed {
    logic [7:0] text_char;
    logic [7:0] ack_char;
    logic [7:0] bin_char;
  } start_cfg_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic       abort;
    logic [7:0] rx_byte;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_comma;
    logic       is_semi;
    logic       is_zero;
    logic       is_one;
    logic       is_start;
    frame_e     start_kind;
  } rx_class_t;

  // one result request
  typedef struct packed {
    kind_e       kind;
    frame_e      frame_type;
    logic [7:0]  frame_id;
    logic [7:0]  data_byte;
    logic        ack_flag;
    logic [15:0] payload_length;
    logic [7:0]  param_count;
    logic [15:0] sum_calculated;
    logic [15:0] sum_received;
    err_e        error_code;
  } result_t;

endpackage

// ----- hw/rtl/tfr_classify.sv -----
// front end: takes input requests and tags each byte with its character class
module tfr_classify import tfr_pkg::*; (
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,
  input  logic [0:0] s_tuser_i,
  input  start_cfg_t start_cfg_i,
  input  logic       q_full_i,
  output logic       push_o,
  output rx_class_t  class_o
);

  logic [7:0] b;
  logic       hit_text;
  logic       hit_ack;
  logic       hit_bin;

  assign b = s_tdata_i;

  // accept whenever the queue has room
  assign s_tready_o = !q_full_i;
  assign push_o     = s_tvalid_i && !q_full_i;

  // start character match, text before acknowledge before binary
  assign hit_text = (b == start_cfg_i.text_char);
  assign hit_ack  = (b == start_cfg_i.ack_char);
  assign hit_bin  = (b == start_cfg_i.bin_char);

  // character classes
  always_comb begin
    class_o.abort    = s_tuser_i[0];
    class_o.rx_byte  = b;
    class_o.is_digit = (b >= CH_ZERO) && (b <= CH_ZERO + 8'd9);
    class_o.digit    = 4'(b - CH_ZERO);
    class_o.is_comma = (b == CH_COMMA);
    class_o.is_semi  = (b == CH_SEMI);
    class_o.is_zero  = (b == CH_ZERO);
    class_o.is_one   = (b == CH_ONE);
    class_o.is_start = hit_text || hit_ack || hit_bin;
    priority if (hit_text) begin
      class_o.start_kind = FRAME_TEXT;
    end else if (hit_ack) begin
      class_o.start_kind = FRAME_ACK;
    end else begin
      class_o.start_kind = FRAME_BIN;
    end
  end

endmodule

// ----- hw/rtl/tfr_queue.sv -----
// small register queue between the classifier and the parser
module tfr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == FULL);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/tfr_parser.sv -----
// back end: frame state machine, number decode, payload sum and result register
module tfr_parser import tfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  rx_class_t   q_data_i,
  output logic        pop_o,
  input  logic [15:0] max_payload_i,
  output logic        out_valid_o,
  input  logic        m_tready_i,
  output result_t     out_o
);

  typedef enum logic [8:0] {
    PH_HUNT   = 9'b000000001,
    PH_ID     = 9'b000000010,
    PH_TEXT   = 9'b000000100,
    PH_ACKVAL = 9'b000001000,
    PH_ACKEND = 9'b000010000,
    PH_LEN    = 9'b000100000,
    PH_PAY    = 9'b001000000,
    PH_PAYEND = 9'b010000000,
    PH_CSUM   = 9'b100000000
  } phase_e;

  phase_e      phase_q, phase_d;
  frame_e      frame_q, frame_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [16:0] acc_q, acc_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] bc_q, bc_d;
  logic [7:0]  sa_q, sa_d;
  logic [7:0]  sb_q, sb_d;
  logic [7:0]  comma_q, comma_d;
  logic        ack_q, ack_d;

  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  result_t     res;

  logic        emit;
  kind_e       emit_kind;
  logic [7:0]  emit_data;
  logic [15:0] emit_srx;
  err_e        emit_err;

  rx_class_t   c;
  logic [16:0] acc_next;
  logic [15:0] bc_inc;

  assign c = q_data_i;

  // take a queued request when the result register is free or drains now
  assign pop_o = q_valid_i && (!out_valid_q || m_tready_i);

  // decimal accumulate: acc * 10 + digit
  assign acc_next = (acc_q << 3) + (acc_q << 1) + {13'd0, c.digit};
  assign bc_inc   = bc_q + 16'd1;

  // frame state machine
  always_comb begin
    phase_d   = phase_q;
    frame_d   = frame_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    id_d      = id_q;
    len_d     = len_q;
    bc_d      = bc_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    comma_d   = comma_q;
    ack_d     = ack_q;
    emit      = 1'b0;
    emit_kind = KIND_DATA;
    emit_data = 8'd0;
    emit_srx  = 16'd0;
    emit_err  = ERR_NONE;

    if (c.abort) begin
      if (phase_q != PH_HUNT) begin
        emit      = 1'b1;
        emit_kind = KIND_ERROR;
        emit_err  = ERR_ABORT;
        phase_d   = PH_HUNT;
      end
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (c.is_start) begin
            frame_d = c.start_kind;
            cnt_d   = '0;
            acc_d   = '0;
            id_d    = '0;
            len_d   = '0;
            bc_d    = '0;
            sa_d    = '0;
            sb_d    = '0;
            comma_d = '0;
            ack_d   = 1'b0;
            phase_d = PH_ID;
          end
        end

        PH_ID: begin
          if (c.is_comma || (frame_q == FRAME_TEXT && c.is_semi)) begin
            if (cnt_q == 3'd0 || acc_q > 17'd255) begin
              emit      = 1'b1;
              emit_kind = KIND_ERROR;
              emit_err  = ERR_NUMBER;
              phase_d   = PH_HUNT;
            end else begin
              id_d  = acc_q[7:0];
              cnt_d = '0;
              acc_d = '0;
              if (frame_q == FRAME_TEXT) begin
                emit = 1'b1;
                if (c.is_semi) begin
                  emit_kind = KIND_DONE;
                  phase_d   = PH_HUNT;
                end else begin
                  // the comma that ends the id is the first text byte
                  comma_d   = 8'd1;
                  bc_d      = 16'd1;
                  emit_kind = KIND_DATA;
                  emit_data = c.rx_byte;
                  phase_d   = PH_TEXT;
                end
              end else begin
                phase_d = (frame_q == FRAME_ACK) ? PH_ACKVAL : PH_LEN;
              end
            end
          end else if (c.is_digit) begin
            if (cnt_q >= ID_DIGITS) begin
              emit      = 1'b1;
              emit_kind = KIND_ERROR;
              emit_err  = ERR_SEP;
              phase_d   = PH_HUNT;
            end else begin
              acc_d = acc_next;
              cnt_d = cnt_q + 3'd1;
            end
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
            emit_err  = (c.is_comma || c.is_semi) ? ERR_SEP : ERR_NUMBER;
            phase_d   = PH_HUNT;
          end
        end

        PH_TEXT: begin
          emit = 1'b1;
          if (c.is_semi) begin
            emit_kind = KIND_DONE;
            phase_d   = PH_HUNT;
          end else if (bc_q >= 16'(TEXT_LIMIT)) begin
            emit_kind = KIND_ERROR;
            emit_err  = ERR_OVERFLOW;
            phase_d   = PH_HUNT;
          end else begin
            if (c.is_comma) begin
              comma_d = comma_q + 8'd1;
            end
            bc_d      = bc_inc;
            emit_kind = KIND_DATA;
            emit_data = c.rx_byte;
          end
        end

        PH_ACKVAL: begin
          if (c.is_zero || c.is_one) begin
            ack_d   = c.is_one;
            phase_d = PH_ACKEND;
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
            emit_err  = ERR_NUMBER;
            phase_d   = PH_HUNT;
          end
        end

        PH_ACKEND: begin
          emit    = 1'b1;
          phase_d = PH_HUNT;
          if (c.is_semi) begin
            emit_kind = KIND_DONE;
          end else begin
            emit_kind = KIND_ERROR;
            emit_err  = ERR_SEP;
          end
        end

        PH_LEN, PH_CSUM: begin
          if (c.is_semi) begin
            emit    = 1'b1;
            phase_d = PH_HUNT;
            if (cnt_q == 3'd0 || acc_q > 17'd65535) begin
              emit_kind = KIND_ERROR;
              emit_err  = ERR_NUMBER;
            end else if (phase_q == PH_LEN) begin
              if (acc_q > {1'b0, max_payload_i}) begin
                emit_kind = KIND_ERROR;
                emit_err  = ERR_TOO_BIG;
              end else begin
                // length accepted, go on quietly
                emit    = 1'b0;
                len_d   = acc_q[15:0];
                cnt_d   = '0;
                acc_d   = '0;
                bc_d    = '0;
                phase_d = (acc_q[15:0] == 16'd0) ? PH_PAYEND : PH_PAY;
              end
            end else begin
              // checksum against the running sum
              emit_srx = acc_q[15:0];
              if (acc_q[15:0] != {sa_q, sb_q}) begin
                emit_kind = KIND_ERROR;
                emit_err  = ERR_CHECKSUM;
              end else begin
                emit_kind = KIND_DONE;
              end
            end
          end else if (c.is_digit) begin
            if (cnt_q >= NUM_DIGITS) begin
              emit      = 1'b1;
              emit_kind = KIND_ERROR;
              emit_err  = ERR_SEP;
              phase_d   = PH_HUNT;
            end else begin
              acc_d = acc_next;
              cnt_d = cnt_q + 3'd1;
            end
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
            emit_err  = c.is_comma ? ERR_SEP : ERR_NUMBER;
            phase_d   = PH_HUNT;
          end
        end

        PH_PAY: begin
          sa_d      = sa_q + c.rx_byte;
          sb_d      = sb_q + sa_d;
          bc_d      = bc_inc;
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_data = c.rx_byte;
          if (bc_inc >= len_q) begin
            phase_d = PH_PAYEND;
          end
        end

        PH_PAYEND: begin
          if (c.is_semi) begin
            phase_d = PH_CSUM;
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
            emit_err  = ERR_SEP;
            phase_d   = PH_HUNT;
          end
        end

        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // result fields reflect the frame state after this byte
  always_comb begin
    res.kind           = emit_kind;
    res.frame_type     = frame_d;
    res.frame_id       = id_d;
    res.data_byte      = emit_data;
    res.ack_flag       = ack_d;
    res.payload_length = len_d;
    res.param_count    = comma_d;
    res.sum_calculated = {sa_d, sb_d};
    res.sum_received   = emit_srx;
    res.error_code     = emit_err;
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_q     <= FRAME_TEXT;
      cnt_q       <= '0;
      acc_q       <= '0;
      id_q        <= '0;
      len_q       <= '0;
      bc_q        <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      comma_q     <= '0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        frame_q <= frame_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        id_q    <= id_d;
        len_q   <= len_d;
        bc_q    <= bc_d;
        sa_q    <= sa_d;
        sb_q    <= sb_d;
        comma_q <= comma_d;
        ack_q   <= ack_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_err_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_ERROR |-> out_q.error_code != ERR_NONE)
    else $error("error result without an error code");
  a_ok_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_ERROR |-> out_q.error_code == ERR_NONE)
    else $error("error code on a non-error result");
  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!out_valid_q || m_tready_i))
    else $error("request taken while the result register is held");
  a_data_no_srx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_DATA |-> out_q.sum_received == 16'd0)
    else $error("received checksum on a data result");
`endif

endmodule

// ----- hw/rtl/text_frame_receiver.sv -----
// top level of the text frame receiver: configuration registers and stream wiring
//
//  channel  | dir | handshake           | contents
//  ---------+-----+---------------------+----------------------------------------
//  s_       | in  | s_tvalid / s_tready | tdata rx_byte, tuser command (1 abort)
//  m_       | out | m_tvalid / m_tready | tdata result fields, tuser kind
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
//  one byte a cycle sustained; a byte enters the queue at its accepting edge, and the
//  parser state machine takes it from the queue and registers its result, if any
//  a four-entry queue lets the input keep flowing while a result waits downstream;
//  the input stalls only once the queue is full behind a held result
//  asynchronous active-low reset; no clearing pass, the block is ready at once
module text_frame_receiver import tfr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,  // [7:0] rx_byte
  input  logic [0:0]  s_tuser_i,  // [0] command
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [1:0] frame_type, [9:2] frame_id, [17:10] data_byte, [18] ack_flag,
  // [34:19] payload_length, [42:35] param_count, [58:43] sum_calculated,
  // [74:59] sum_received, [77:75] error_code, [79:78] zero
  output logic [79:0] m_tdata_o,
  output logic [1:0]  m_tuser_o,  // [1:0] kind
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CW = $bits(rx_class_t);

  start_cfg_t  start_cfg_q;
  logic [15:0] max_payload_q;

  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  rx_class_t   cls;
  logic [CW-1:0] q_rdata;
  result_t     res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cfg_q.text_char <= 8'd35;
      start_cfg_q.ack_char  <= 8'd33;
      start_cfg_q.bin_char  <= 8'd36;
      max_payload_q         <= 16'd65535;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TEXT_START:  start_cfg_q.text_char <= cfg_data_i[7:0];
        CFG_ACK_START:   start_cfg_q.ack_char  <= cfg_data_i[7:0];
        CFG_BIN_START:   start_cfg_q.bin_char  <= cfg_data_i[7:0];
        CFG_MAX_PAYLOAD: max_payload_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify
  tfr_classify u_classify (
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .start_cfg_i (start_cfg_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .class_o     (cls)
  );

  // queue between front and back
  tfr_queue #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // back: parse and hold the result
  tfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (rx_class_t'(q_rdata)),
    .pop_o         (pop),
    .max_payload_i (max_payload_q),
    .out_valid_o   (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .out_o         (res)
  );

  // result packing
  assign m_tuser_o = res.kind;
  assign m_tdata_o = {2'b00, res.error_code, res.sum_received, res.sum_calculated,
                      res.param_count, res.payload_length, res.ack_flag,
                      res.data_byte, res.frame_id, res.frame_type};

endmodule

// ----- dv/text_frame_receiver_tb.sv -----
// self-checking stream testbench for the text frame receiver
`timescale 1ns / 100ps

module text_frame_receiver_tb;
  import tfr_pkg::*;

  // parser phases of the byte-level frame decoder
  typedef enum logic [3:0] {
    ST_HUNT, ST_ID, ST_TEXT, ST_ACKVAL, ST_ACKEND, ST_LEN, ST_PAY, ST_PAYEND, ST_CSUM
  } rx_phase_e;

  // outcome of one byte offered to a decimal number
  localparam int DIGIT_TAKEN = 0;
  localparam int NUM_DONE    = -1;

  // one row of the directed byte table
  typedef struct {
    logic       cmd;
    logic [7:0] b;
    bit         typed;
    bit         has;
    kind_e      kind;
    err_e       err;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = 8'h00;  // [7:0] rx_byte
  logic [0:0]  s_tuser_i = 1'b0;   // [0] command
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  // [1:0] frame_type, [9:2] frame_id, [17:10] data_byte, [18] ack_flag,
  // [34:19] payload_length, [42:35] param_count, [58:43] sum_calculated,
  // [74:59] sum_received, [77:75] error_code, [79:78] zero
  logic [79:0] m_tdata_o;
  logic [1:0]  m_tuser_o;          // [1:0] kind
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [15:0] cfg_data_i = 16'h0000;

  // decoder copy: programmed registers
  logic [7:0]  text_ch, ack_ch, bin_ch;
  logic [15:0] pay_limit;

  // decoder copy: frame state
  rx_phase_e   rx_phase;
  frame_e      cur_kind;
  logic [2:0]  digits_seen;
  logic [16:0] num_acc;
  logic [7:0]  frame_id_v;
  logic [15:0] pay_len;
  logic [15:0] byte_cnt;
  logic [7:0]  fl_a, fl_b;
  logic [7:0]  commas;
  logic        ack_bit;

  result_t     due_results[$];
  logic [8:0]  frame_bytes[$];  // {command, rx_byte}
  int unsigned mismatches = 0;
  int unsigned bytes_fed = 0;
  int unsigned sender_pct = 0;
  int unsigned recv_pct = 0;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // register settings and idle rates of the random phases
  logic [15:0] reg_plan [4][4] = '{
    '{16'd35, 16'd33, 16'd36, 16'd65535},
    '{16'd0, 16'd255, 16'd128, 16'd0},
    '{16'd255, 16'd0, 16'd1, 16'd40},
    '{16'd64, 16'd64, 16'd42, 16'd300}
  };
  int unsigned gap_plan [4] = '{0, 86, 0, 15};
  int unsigned stall_plan [4] = '{0, 0, 86, 15};

  text_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // clear everything the frame collects, phase aside
  function automatic void clear_frame();
    cur_kind = FRAME_TEXT;
    digits_seen = '0;
    num_acc = '0;
    frame_id_v = '0;
    pay_len = '0;
    byte_cnt = '0;
    fl_a = '0;
    fl_b = '0;
    commas = '0;
    ack_bit = 1'b0;
  endfunction

  // one byte of a decimal field
  function automatic int take_digit(logic [7:0] b, logic [2:0] maxd, logic [7:0] term);
    if (b == term) return NUM_DONE;
    if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) begin
      if (digits_seen >= maxd) return int'(ERR_SEP);
      num_acc = 17'(num_acc * 10 + (b - CH_ZERO));
      digits_seen = digits_seen + 3'd1;
      return DIGIT_TAKEN;
    end
    if (b == CH_COMMA || b == CH_SEMI) return int'(ERR_SEP);
    return int'(ERR_NUMBER);
  endfunction

  function automatic result_t form_result(kind_e k, logic [7:0] d, logic [15:0] srx, err_e e);
    result_t r;
    r.kind = k;
    r.frame_type = cur_kind;
    r.frame_id = frame_id_v;
    r.data_byte = d;
    r.ack_flag = ack_bit;
    r.payload_length = pay_len;
    r.param_count = commas;
    r.sum_calculated = {fl_a, fl_b};
    r.sum_received = srx;
    r.error_code = e;
    return r;
  endfunction

  // completion or error closes the frame
  function automatic result_t end_frame(kind_e k, err_e e, logic [15:0] srx);
    rx_phase = ST_HUNT;
    return form_result(k, 8'h00, srx, e);
  endfunction

  // decode one accepted request, returns 1 when it yields a result
  function automatic bit decode_rx(logic cmd, logic [7:0] b, output result_t r);
    int st;
    logic [7:0] term;
    r = '0;
    if (cmd) begin
      if (rx_phase == ST_HUNT) return 1'b0;
      r = end_frame(KIND_ERROR, ERR_ABORT, 16'h0);
      return 1'b1;
    end
    case (rx_phase)
      ST_HUNT: begin
        if (b == text_ch) begin
          clear_frame();
          cur_kind = FRAME_TEXT;
        end else if (b == ack_ch) begin
          clear_frame();
          cur_kind = FRAME_ACK;
        end else if (b == bin_ch) begin
          clear_frame();
          cur_kind = FRAME_BIN;
        end else begin
          return 1'b0;
        end
        rx_phase = ST_ID;
        return 1'b0;
      end
      ST_ID: begin
        // a text id may also end at the semicolon
        term = (cur_kind == FRAME_TEXT && b == CH_SEMI) ? CH_SEMI : CH_COMMA;
        st = take_digit(b, ID_DIGITS, term);
        if (st > 0) begin
          r = end_frame(KIND_ERROR, err_e'(st[2:0]), 16'h0);
          return 1'b1;
        end
        if (st == DIGIT_TAKEN) return 1'b0;
        if (digits_seen == 0 || num_acc > 255) begin
          r = end_frame(KIND_ERROR, ERR_NUMBER, 16'h0);
          return 1'b1;
        end
        frame_id_v = num_acc[7:0];
        digits_seen = '0;
        num_acc = '0;
        if (cur_kind == FRAME_TEXT) begin
          if (b == CH_SEMI) begin
            r = end_frame(KIND_DONE, ERR_NONE, 16'h0);
            return 1'b1;
          end
          // the comma after the id is the first text byte
          commas = 8'd1;
          byte_cnt = 16'd1;
          rx_phase = ST_TEXT;
          r = form_result(KIND_DATA, b, 16'h0, ERR_NONE);
          return 1'b1;
        end
        rx_phase = (cur_kind == FRAME_ACK) ? ST_ACKVAL : ST_LEN;
        return 1'b0;
      end
      ST_TEXT: begin
        if (b == CH_SEMI) begin
          r = end_frame(KIND_DONE, ERR_NONE, 16'h0);
          return 1'b1;
        end
        if (byte_cnt >= TEXT_LIMIT) begin
          r = end_frame(KIND_ERROR, ERR_OVERFLOW, 16'h0);
          return 1'b1;
        end
        if (b == CH_COMMA) commas = commas + 8'd1;
        byte_cnt = byte_cnt + 16'd1;
        r = form_result(KIND_DATA, b, 16'h0, ERR_NONE);
        return 1'b1;
      end
      ST_ACKVAL: begin
        if (b == CH_ZERO) begin
          ack_bit = 1'b0;
        end else if (b == CH_ONE) begin
          ack_bit = 1'b1;
        end else begin
          r = end_frame(KIND_ERROR, ERR_NUMBER, 16'h0);
          return 1'b1;
        end
        rx_phase = ST_ACKEND;
        return 1'b0;
      end
      ST_ACKEND: begin
        if (b != CH_SEMI) r = end_frame(KIND_ERROR, ERR_SEP, 16'h0);
        else r = end_frame(KIND_DONE, ERR_NONE, 16'h0);
        return 1'b1;
      end
      ST_LEN: begin
        st = take_digit(b, NUM_DIGITS, CH_SEMI);
        if (st > 0) begin
          r = end_frame(KIND_ERROR, err_e'(st[2:0]), 16'h0);
          return 1'b1;
        end
        if (st == DIGIT_TAKEN) return 1'b0;
        if (digits_seen == 0 || num_acc > 65535) begin
          r = end_frame(KIND_ERROR, ERR_NUMBER, 16'h0);
          return 1'b1;
        end
        if (num_acc > pay_limit) begin
          r = end_frame(KIND_ERROR, ERR_TOO_BIG, 16'h0);
          return 1'b1;
        end
        pay_len = num_acc[15:0];
        digits_seen = '0;
        num_acc = '0;
        byte_cnt = '0;
        // zero length goes straight to the closing semicolon
        rx_phase = (pay_len == 0) ? ST_PAYEND : ST_PAY;
        return 1'b0;
      end
      ST_PAY: begin
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= pay_len) rx_phase = ST_PAYEND;
        r = form_result(KIND_DATA, b, 16'h0, ERR_NONE);
        return 1'b1;
      end
      ST_PAYEND: begin
        if (b != CH_SEMI) begin
          r = end_frame(KIND_ERROR, ERR_SEP, 16'h0);
          return 1'b1;
        end
        rx_phase = ST_CSUM;
        return 1'b0;
      end
      ST_CSUM: begin
        st = take_digit(b, NUM_DIGITS, CH_SEMI);
        if (st > 0) begin
          r = end_frame(KIND_ERROR, err_e'(st[2:0]), 16'h0);
          return 1'b1;
        end
        if (st == DIGIT_TAKEN) return 1'b0;
        if (digits_seen == 0 || num_acc > 65535) begin
          r = end_frame(KIND_ERROR, ERR_NUMBER, 16'h0);
          return 1'b1;
        end
        if (num_acc[15:0] != {fl_a, fl_b}) r = end_frame(KIND_ERROR, ERR_CHECKSUM, num_acc[15:0]);
        else r = end_frame(KIND_DONE, ERR_NONE, num_acc[15:0]);
        return 1'b1;
      end
      default: begin
        rx_phase = ST_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // offer one request with a random gap before it, return once it is taken
  task automatic offer(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < sender_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    s_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic feed(logic cmd, logic [7:0] b);
    result_t r;
    offer(cmd, b);
    if (decode_rx(cmd, b, r)) due_results.push_back(r);
    bytes_fed++;
  endtask

  // stop sending until every result is out, then let the pipeline settle
  task automatic drain_results(int unsigned settle);
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // write all four registers from one row of the plan
  task automatic program_regs(int p);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i <= reg_plan[p][i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (cfg_reg_e'(i))
        CFG_TEXT_START: text_ch = reg_plan[p][i][7:0];
        CFG_ACK_START:  ack_ch = reg_plan[p][i][7:0];
        CFG_BIN_START:  bin_ch = reg_plan[p][i][7:0];
        default:        pay_limit = reg_plan[p][i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void put(logic cmd, logic [7:0] b);
    frame_bytes.push_back({cmd, b});
  endfunction

  // decimal text, now and then empty or with an extra leading zero
  function automatic void push_dec(int unsigned v);
    string s;
    if ($urandom_range(23) == 0) return;
    if ($urandom_range(23) == 0) put(1'b0, CH_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) put(1'b0, s[i]);
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(3) == 0) return CH_COMMA;
    do c = 8'($urandom); while (c == CH_SEMI);
    return c;
  endfunction

  // one frame of random content, mostly well formed
  task automatic build_frame(bit long_text);
    int unsigned pick, sel, n, len, id, pos, csum;
    logic [7:0] fa, fb, pb;
    frame_bytes.delete();
    pick = long_text ? 0 : $urandom_range(99);
    id = ($urandom_range(9) == 0) ? $urandom_range(999) : $urandom_range(255);
    if (pick < 30) begin
      put(1'b0, text_ch);
      push_dec(id);
      if (!long_text && $urandom_range(6) == 0) begin
        put(1'b0, CH_SEMI);
      end else begin
        put(1'b0, CH_COMMA);
        if (long_text) n = 100;
        else if ($urandom_range(19) == 0) n = $urandom_range(135, 120);
        else n = $urandom_range(20);
        repeat (n) put(1'b0, text_char());
        put(1'b0, CH_SEMI);
      end
    end else if (pick < 50) begin
      put(1'b0, ack_ch);
      push_dec(id);
      put(1'b0, CH_COMMA);
      if ($urandom_range(15) == 0) put(1'b0, 8'($urandom));
      else put(1'b0, CH_ZERO + 8'($urandom_range(1)));
      put(1'b0, CH_SEMI);
    end else if (pick < 85) begin
      sel = $urandom_range(99);
      if (sel < 70) len = $urandom_range(16);
      else if (sel < 94) len = $urandom_range(64, 17);
      else if (sel < 98) len = $urandom_range(400, 200);
      else len = $urandom_range(99999, 65536);
      if (len > pay_limit && $urandom_range(4) != 0)
        len = $urandom_range(pay_limit < 64 ? pay_limit : 64);
      put(1'b0, bin_ch);
      push_dec(id);
      put(1'b0, CH_COMMA);
      push_dec(len);
      put(1'b0, CH_SEMI);
      if (len <= pay_limit) begin
        fa = '0;
        fb = '0;
        repeat (len) begin
          pb = 8'($urandom);
          fa = fa + pb;
          fb = fb + fa;
          put(1'b0, pb);
        end
        put(1'b0, CH_SEMI);
        csum = ($urandom_range(7) == 0) ? $urandom_range(65535) : {fa, fb};
        push_dec(csum);
        put(1'b0, CH_SEMI);
      end
    end else begin
      // line noise and stray aborts
      n = $urandom_range(4, 1);
      repeat (n) put($urandom_range(7) == 0, 8'($urandom));
    end
    // broken frames: a byte swapped, an abort, or a cut short
    if (pick < 85 && !long_text && $urandom_range(7) == 0) begin
      pos = $urandom_range(frame_bytes.size() - 1);
      case ($urandom_range(2))
        0: frame_bytes[pos] = {1'b0, 8'($urandom)};
        1: frame_bytes[pos] = {1'b1, 8'($urandom)};
        default: begin
          while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
          put(1'b1, 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic send_frame(bit long_text);
    build_frame(long_text);
    foreach (frame_bytes[i]) feed(frame_bytes[i][8], frame_bytes[i][7:0]);
  endtask

  // receiver ready: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= 150;
      m_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic cmp_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      mismatches++;
    end
  endtask

  // compare each result request with the oldest one due
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d data %h", m_tuser_o, m_tdata_o);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        cmp_field("kind", want.kind, m_tuser_o);
        cmp_field("frame_type", want.frame_type, m_tdata_o[1:0]);
        cmp_field("frame_id", want.frame_id, m_tdata_o[9:2]);
        cmp_field("data_byte", want.data_byte, m_tdata_o[17:10]);
        cmp_field("ack_flag", want.ack_flag, m_tdata_o[18]);
        cmp_field("payload_length", want.payload_length, m_tdata_o[34:19]);
        cmp_field("param_count", want.param_count, m_tdata_o[42:35]);
        cmp_field("sum_calculated", want.sum_calculated, m_tdata_o[58:43]);
        cmp_field("sum_received", want.sum_received, m_tdata_o[74:59]);
        cmp_field("error_code", want.error_code, m_tdata_o[77:75]);
      end
    end
  end

  // directed bytes at reset settings
  probe_t probes [25] = '{
    '{1'b0, 8'hFF, 1'b1, 1'b0, KIND_DATA, ERR_NONE},       // junk while hunting
    '{1'b1, 8'h00, 1'b1, 1'b0, KIND_DATA, ERR_NONE},       // abort while hunting
    '{1'b0, "#", 1'b1, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, "2", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, "5", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, "5", 1'b0, 1'b0, KIND_DATA, ERR_NONE},         // largest id
    '{1'b0, CH_COMMA, 1'b1, 1'b1, KIND_DATA, ERR_NONE},    // comma is first text byte
    '{1'b0, CH_SEMI, 1'b1, 1'b1, KIND_DONE, ERR_NONE},
    '{1'b0, "!", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, "1", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_COMMA, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_ONE, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_SEMI, 1'b1, 1'b1, KIND_DONE, ERR_NONE},
    '{1'b0, "$", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_ZERO, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_COMMA, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_ZERO, 1'b0, 1'b0, KIND_DATA, ERR_NONE},     // zero length
    '{1'b0, CH_SEMI, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_SEMI, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_ZERO, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, CH_SEMI, 1'b1, 1'b1, KIND_DONE, ERR_NONE},
    '{1'b0, "#", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b1, 8'h5A, 1'b1, 1'b1, KIND_ERROR, ERR_ABORT},     // abort inside a frame
    '{1'b0, "!", 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{1'b0, "x", 1'b1, 1'b1, KIND_ERROR, ERR_NUMBER}       // non-digit id
  };

  initial begin : stimulus
    result_t r;
    bit got;
    bit paused;
    int unsigned target;

    text_ch = 8'd35;
    ack_ch = 8'd33;
    bin_ch = 8'd36;
    pay_limit = 16'hFFFF;
    rx_phase = ST_HUNT;
    clear_frame();
    paused = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (probes[i]) begin
      offer(probes[i].cmd, probes[i].b);
      got = decode_rx(probes[i].cmd, probes[i].b, r);
      bytes_fed++;
      if (probes[i].typed) begin
        if (got != probes[i].has ||
            (got && (r.kind != probes[i].kind || r.error_code != probes[i].err))) begin
          $error("row %0d: decoder gives result %0d kind %0d error %0d", i, got, r.kind,
                 r.error_code);
          mismatches++;
        end
        if (probes[i].has) begin
          r.kind = probes[i].kind;
          r.error_code = probes[i].err;
          due_results.push_back(r);
        end
      end else if (got) begin
        due_results.push_back(r);
      end
    end

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < 4; p++) begin
      drain_results(12);
      program_regs(p);
      sender_pct = gap_plan[p];
      recv_pct <= stall_plan[p];
      target = bytes_fed + 412;
      if (p == 0) begin
        // hold the result side off while a long text frame streams in
        hold_tog <= ~hold_tog;
        send_frame(1'b1);
      end
      while (bytes_fed < target) begin
        send_frame(1'b0);
        if (p == 1 && !paused && bytes_fed + 200 >= target) begin
          paused = 1'b1;
          drain_results(0);
        end
      end
    end

    drain_results(12);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_classify.sv
hw/rtl/tfr_queue.sv
hw/rtl/tfr_parser.sv
hw/rtl/text_frame_receiver.sv
dv/text_frame_receiver_tb.sv
